// ===== sv/i2c_master_bit_sequencer_macros.svh =====
// Assertion macros used by the checker file of the I2C master bit sequencer.
`ifndef I2C_MASTER_BIT_SEQUENCER_MACROS_SVH
`define I2C_MASTER_BIT_SEQUENCER_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset
`define I2CMS_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("i2c bit sequencer check failed");

// Next-cycle implication, sampled on clk, off during reset
`define I2CMS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("i2c bit sequencer check failed");

`endif

// ===== sv/i2cms_pkg.sv =====
// Types and constants of the I2C master bit sequencer.
package i2cms_pkg;

    // Bit count of one byte and the slot numbering of a byte transfer
    localparam int BIT_COUNT = 8;
    localparam int SLOT_W    = 5;

    localparam logic [SLOT_W-1:0] DATA_END  = SLOT_W'(2 * BIT_COUNT);
    localparam logic [SLOT_W-1:0] ACK_SLOT  = SLOT_W'(2 * BIT_COUNT + 1);
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(2 * BIT_COUNT + 2);

    localparam logic [7:0] TOP_BIT = 8'h80;

    // Command codes on the mode field
    typedef enum logic [2:0] {
        MODE_TICK  = 3'd0,
        MODE_START = 3'd1,
        MODE_STOP  = 3'd2,
        MODE_SEND  = 3'd3,
        MODE_RECV  = 3'd4
    } mode_t;

    // Command in progress
    typedef enum logic [2:0] {
        KIND_IDLE  = 3'd0,
        KIND_START = 3'd1,
        KIND_STOP  = 3'd2,
        KIND_SEND  = 3'd3,
        KIND_RECV  = 3'd4
    } kind_t;

endpackage

// ===== sv/i2c_master_bit_sequencer.sv =====
// I2C master bit sequencer: an accepted item passes the input register, then the result register.
// Throughput one item per cycle; the input register holds while the result
// register is stalled, and the result register is the only buffer on the output.
// Bus state advances by one slot per accepted tick item.
// Reset (rst_n low, asynchronous) leaves the engine idle, SCL and SDA high, SDA driven.
module i2c_master_bit_sequencer
    import i2cms_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [2:0] mode,
    input  logic [7:0] tx_byte,
    input  logic       nack_after_read,
    input  logic       sda_in,
    output logic       out_valid,
    input  logic       out_stall,
    output logic       scl_level,
    output logic       sda_level,
    output logic       sda_drive,
    output logic       busy_res,
    output logic       done_res,
    output logic [7:0] rx_byte,
    output logic       ack_level,
    output logic       refused
);

    // Input register
    logic       in_vld_reg;
    mode_t      mode_reg;
    logic [7:0] tx_reg;
    logic       nack_in_reg;
    logic       sda_in_reg;

    // Engine state
    kind_t             kind_reg,    kind_next;
    logic [SLOT_W-1:0] slot_reg,    slot_next;
    logic [7:0]        shift_reg,   shift_next;
    logic              nack_reg,    nack_next;
    logic              scl_reg,     scl_next;
    logic              sda_reg,     sda_next;
    logic              sda_en_reg,  sda_en_next;
    logic              ack_reg,     ack_next;
    logic [7:0]        rx_hold_reg, rx_hold_next;

    // Result register
    logic       out_vld_reg;
    logic       scl_out_reg;
    logic       sda_out_reg;
    logic       drv_out_reg;
    logic       busy_out_reg;
    logic       done_out_reg;
    logic [7:0] rx_out_reg;
    logic       ack_out_reg;
    logic       ref_out_reg;

    logic              out_free;
    logic              fire;
    logic              done_c;
    logic              refused_c;
    logic [SLOT_W-1:0] slot_inc;

    assign out_free = !out_vld_reg || !out_stall;
    assign fire     = in_vld_reg && out_free;
    assign in_stall = in_vld_reg && !out_free;
    assign slot_inc = slot_reg + SLOT_W'(1);

    // Capture an item whenever the input register empties or moves on
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            in_vld_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            mode_reg    <= mode_t'(mode);
            tx_reg      <= tx_byte;
            nack_in_reg <= nack_after_read;
            sda_in_reg  <= sda_in;
        end
    end

    // Step the engine by one item
    always_comb
    begin
        kind_next    = kind_reg;
        slot_next    = slot_reg;
        shift_next   = shift_reg;
        nack_next    = nack_reg;
        scl_next     = scl_reg;
        sda_next     = sda_reg;
        sda_en_next  = sda_en_reg;
        ack_next     = ack_reg;
        rx_hold_next = rx_hold_reg;
        done_c       = 1'b0;
        refused_c    = 1'b0;

        unique case (mode_reg) inside
            MODE_TICK:
            begin
                unique case (kind_reg) inside
                    KIND_START:
                    begin
                        if (slot_reg == '0)
                        begin
                            sda_next  = 1'b0;
                            slot_next = SLOT_W'(1);
                        end
                        else
                        begin
                            scl_next = 1'b0;
                            done_c   = 1'b1;
                        end
                    end
                    KIND_STOP:
                    begin
                        sda_next = 1'b1;
                        done_c   = 1'b1;
                    end
                    KIND_SEND, KIND_RECV:
                    begin
                        if (slot_inc >= LAST_SLOT)
                        begin
                            // Closing low clock phase
                            scl_next = 1'b0;
                            if (kind_reg == KIND_RECV)
                            begin
                                rx_hold_next = shift_reg;
                            end
                            done_c = 1'b1;
                        end
                        else if (slot_inc[0])
                        begin
                            // Rising clock: sample data or ack
                            scl_next  = 1'b1;
                            slot_next = slot_inc;
                            if (kind_reg == KIND_RECV && slot_inc < DATA_END)
                            begin
                                shift_next = {shift_reg[6:0], sda_in_reg};
                            end
                            if (kind_reg == KIND_SEND && slot_inc == ACK_SLOT)
                            begin
                                ack_next = sda_in_reg;
                            end
                        end
                        else
                        begin
                            // Falling clock: set up the next bit
                            scl_next  = 1'b0;
                            slot_next = slot_inc;
                            if (kind_reg == KIND_SEND)
                            begin
                                if (slot_inc < DATA_END)
                                begin
                                    shift_next = {shift_reg[6:0], 1'b0};
                                    sda_next   = shift_reg[6];
                                end
                                else
                                begin
                                    sda_en_next = 1'b0;
                                end
                            end
                            else if (slot_inc == DATA_END)
                            begin
                                sda_en_next = 1'b1;
                                sda_next    = nack_reg;
                            end
                        end
                    end
                    default:
                    begin
                    end
                endcase
                if (done_c)
                begin
                    kind_next = KIND_IDLE;
                    slot_next = '0;
                end
            end
            MODE_START, MODE_STOP, MODE_SEND, MODE_RECV:
            begin
                if (kind_reg != KIND_IDLE)
                begin
                    refused_c = 1'b1;
                end
                else
                begin
                    kind_next = kind_t'(mode_reg);
                    slot_next = '0;
                    unique case (mode_reg) inside
                        MODE_START:
                        begin
                            sda_en_next = 1'b1;
                            sda_next    = 1'b1;
                            scl_next    = 1'b1;
                        end
                        MODE_STOP:
                        begin
                            sda_en_next = 1'b1;
                            sda_next    = 1'b0;
                            scl_next    = 1'b1;
                        end
                        MODE_SEND:
                        begin
                            shift_next  = tx_reg;
                            sda_en_next = 1'b1;
                            sda_next    = (tx_reg & TOP_BIT) != 8'h00;
                            scl_next    = 1'b0;
                        end
                        default:
                        begin
                            shift_next  = '0;
                            nack_next   = nack_in_reg;
                            sda_en_next = 1'b0;
                            scl_next    = 1'b0;
                        end
                    endcase
                end
            end
            default:
            begin
            end
        endcase
    end

    // Commit engine state when the item moves into the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kind_reg    <= KIND_IDLE;
            slot_reg    <= '0;
            shift_reg   <= '0;
            nack_reg    <= 1'b0;
            scl_reg     <= 1'b1;
            sda_reg     <= 1'b1;
            sda_en_reg  <= 1'b1;
            ack_reg     <= 1'b0;
            rx_hold_reg <= '0;
        end
        else if (fire)
        begin
            kind_reg    <= kind_next;
            slot_reg    <= slot_next;
            shift_reg   <= shift_next;
            nack_reg    <= nack_next;
            scl_reg     <= scl_next;
            sda_reg     <= sda_next;
            sda_en_reg  <= sda_en_next;
            ack_reg     <= ack_next;
            rx_hold_reg <= rx_hold_next;
        end
    end

    // Result valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_vld_reg <= in_vld_reg;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            scl_out_reg  <= scl_next;
            sda_out_reg  <= sda_next;
            drv_out_reg  <= sda_en_next;
            busy_out_reg <= kind_next != KIND_IDLE;
            done_out_reg <= done_c;
            rx_out_reg   <= rx_hold_next;
            ack_out_reg  <= ack_next;
            ref_out_reg  <= refused_c;
        end
    end

    assign out_valid = out_vld_reg;
    assign scl_level = scl_out_reg;
    assign sda_level = sda_out_reg;
    assign sda_drive = drv_out_reg;
    assign busy_res  = busy_out_reg;
    assign done_res  = done_out_reg;
    assign rx_byte   = rx_out_reg;
    assign ack_level = ack_out_reg;
    assign refused   = ref_out_reg;

endmodule

// ===== sv/i2cms_checker.sv =====
// Port-level checks of the I2C master bit sequencer and their bind.
`include "i2c_master_bit_sequencer_macros.svh"

module i2cms_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_stall,
    input logic [2:0] mode,
    input logic [7:0] tx_byte,
    input logic       nack_after_read,
    input logic       sda_in,
    input logic       out_valid,
    input logic       out_stall,
    input logic       scl_level,
    input logic       sda_level,
    input logic       sda_drive,
    input logic       busy_res,
    input logic       done_res,
    input logic [7:0] rx_byte,
    input logic       ack_level,
    input logic       refused
);

    // A finished command leaves the engine idle
    `I2CMS_ASSERT_NOW(a_done_idle, out_valid && done_res, !busy_res)

    // A refused item only happens while a command runs, and it keeps running
    `I2CMS_ASSERT_NOW(a_refused_busy, out_valid && refused, busy_res && !done_res)

    // A stalled result holds
    `I2CMS_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
        out_valid && $stable(rx_byte) && $stable(done_res) && $stable(scl_level))

endmodule

bind i2c_master_bit_sequencer i2cms_checker u_i2cms_checker (.*);
